/* design/srs_pkg.sv */
package srs_pkg;

    // Position format: unsigned integer part above FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 24;
    localparam int POS_W     = FRAC_BITS + 9;
    localparam int STEP_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = FRAC_BITS + SAMPLE_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [POS_W-1:0]  ONE_POS  = POS_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_BITS - 6);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_STEP    = 2'd1;

    localparam logic                RST_INTERP_MODE = 1'b1;
    localparam logic [STEP_W-1:0]   RST_POS_STEP    = STEP_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last_of_run;
    } t_out_word;

endpackage

/* design/stereo_linear_resampler.sv */
// Stereo linear resampler. Each input word is one signed 16-bit stereo
// sample; each output word is one resampled stereo sample, with last_of_run
// set on the final output caused by an input. The read position is unsigned
// 9.24 fixed point; the position increment (register 1) is added per output and
// is raised to 2^-6 if set lower, so one input causes at most 64 outputs. interp_mode
// (register 0) selects linear interpolation (1) or holding the older sample
// (0). Both channels share one multiplier with a registered product, so each
// output passes through S_MUL_L, S_MUL_R, S_FIN_R and S_EMIT, which waits while
// the output side stalls. An input that causes no output only slides the window.
// Input ready is low while outputs are made; the last output may still wait in the
// output register while the next input is taken. Configure only when idle.
module stereo_linear_resampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  srs_pkg::t_in_word                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output srs_pkg::t_out_word                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [srs_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_FIN_R,
        S_EMIT
    } t_state;

    t_state r_state;

    logic                                 r_interp_mode;
    logic [srs_pkg::STEP_W-1:0]           r_pos_step;
    logic [srs_pkg::POS_W-1:0]            r_pos;
    logic [srs_pkg::POS_W-1:0]            r_pos_adv;
    logic signed [srs_pkg::SAMPLE_W-1:0]  r_old_l, r_old_r;
    logic signed [srs_pkg::SAMPLE_W-1:0]  r_mid_l, r_mid_r;
    logic signed [srs_pkg::SAMPLE_W-1:0]  r_new_l, r_new_r;
    logic signed [srs_pkg::SAMPLE_W-1:0]  r_res_l, r_res_r;
    logic                                 r_out_valid;
    srs_pkg::t_out_word                   r_out_data;

    logic [srs_pkg::STEP_W-1:0]           step_eff;
    logic [srs_pkg::POS_W-1:0]            n_pos_adv;
    logic signed [srs_pkg::SAMPLE_W-1:0]  unit_older, unit_newer;
    logic signed [srs_pkg::SAMPLE_W-1:0]  unit_result;
    logic signed [srs_pkg::SAMPLE_W-1:0]  res_l_sel, res_r_sel;
    logic                                 pos_whole;
    logic                                 adv_whole;
    logic                                 in_fire;
    logic                                 out_free;
    logic                                 emit_fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign emit_fire = (r_state == S_EMIT) && out_free;

    // Effective step with its lower bound, and the advanced position.
    assign step_eff  = (r_pos_step < srs_pkg::MIN_STEP) ? srs_pkg::MIN_STEP : r_pos_step;
    assign n_pos_adv = r_pos + srs_pkg::POS_W'(step_eff);
    assign pos_whole = |r_pos[srs_pkg::POS_W-1:srs_pkg::FRAC_BITS];
    assign adv_whole = |r_pos_adv[srs_pkg::POS_W-1:srs_pkg::FRAC_BITS];

    // Channel select for the shared interpolation unit.
    always_comb begin
        if (r_state == S_MUL_R) begin
            unit_older = r_old_r;
            unit_newer = r_mid_r;
        end else begin
            unit_older = r_old_l;
            unit_newer = r_mid_l;
        end
    end

    srs_lerp_unit u_lerp (
        .i_clk    (i_clk),
        .i_older  (unit_older),
        .i_newer  (unit_newer),
        .i_frac   (r_pos[srs_pkg::FRAC_BITS-1:0]),
        .o_result (unit_result)
    );

    // Hold mode passes the older sample through.
    assign res_l_sel = r_interp_mode ? unit_result : r_old_l;
    assign res_r_sel = r_interp_mode ? unit_result : r_old_r;

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_interp_mode <= srs_pkg::RST_INTERP_MODE;
            r_pos_step    <= srs_pkg::RST_POS_STEP;
            r_pos         <= '0;
            r_old_l       <= '0;
            r_old_r       <= '0;
            r_mid_l       <= '0;
            r_mid_r       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    srs_pkg::CFG_INTERP_MODE: r_interp_mode <= i_cfg_data[0];
                    srs_pkg::CFG_POS_STEP:    r_pos_step    <= i_cfg_data[srs_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end

            // The output register loads a new word, or empties once its word is taken.
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_new_l <= i_in_data.left_in;
                        r_new_r <= i_in_data.right_in;
                        if (pos_whole) begin
                            // No output this time: just slide the window.
                            r_old_l <= r_mid_l;
                            r_old_r <= r_mid_r;
                            r_mid_l <= i_in_data.left_in;
                            r_mid_r <= i_in_data.right_in;
                            r_pos   <= r_pos - srs_pkg::ONE_POS;
                        end else begin
                            r_state <= S_MUL_L;
                        end
                    end
                end
                S_MUL_L: begin
                    r_pos_adv <= n_pos_adv;
                    r_state   <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_res_l <= res_l_sel;
                    r_state <= S_FIN_R;
                end
                S_FIN_R: begin
                    r_res_r <= res_r_sel;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_data.left_out    <= r_res_l;
                        r_out_data.right_out   <= r_res_r;
                        r_out_data.last_of_run <= adv_whole;
                        if (adv_whole) begin
                            r_old_l <= r_mid_l;
                            r_old_r <= r_mid_r;
                            r_mid_l <= r_new_l;
                            r_mid_r <= r_new_r;
                            r_pos   <= r_pos_adv - srs_pkg::ONE_POS;
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos_adv;
                            r_state <= S_MUL_L;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/srs_lerp_unit.sv */
module srs_lerp_unit (
    input  logic                                  i_clk,
    input  logic signed [srs_pkg::SAMPLE_W-1:0]   i_older,
    input  logic signed [srs_pkg::SAMPLE_W-1:0]   i_newer,
    input  logic        [srs_pkg::FRAC_BITS-1:0]  i_frac,
    output logic signed [srs_pkg::SAMPLE_W-1:0]   o_result
);

    logic signed [srs_pkg::SAMPLE_W:0]     delta;
    logic signed [srs_pkg::SAMPLE_W-1:0]   delta_sat;
    logic signed [srs_pkg::FRAC_BITS:0]    frac_s;
    logic signed [srs_pkg::PROD_W-1:0]     n_prod;
    logic signed [srs_pkg::PROD_W-1:0]     r_prod;
    logic signed [srs_pkg::SAMPLE_W-1:0]   r_older;

    // Difference of the two samples, saturated to the sample range.
    always_comb begin
        delta = (srs_pkg::SAMPLE_W+1)'(i_newer) - (srs_pkg::SAMPLE_W+1)'(i_older);
        if (delta > (srs_pkg::SAMPLE_W+1)'(srs_pkg::SAMPLE_MAX)) begin
            delta_sat = srs_pkg::SAMPLE_MAX;
        end else if (delta < (srs_pkg::SAMPLE_W+1)'(srs_pkg::SAMPLE_MIN)) begin
            delta_sat = srs_pkg::SAMPLE_MIN;
        end else begin
            delta_sat = delta[srs_pkg::SAMPLE_W-1:0];
        end
        frac_s = $signed({1'b0, i_frac});
        n_prod = srs_pkg::PROD_W'(frac_s) * srs_pkg::PROD_W'(delta_sat);
    end

    // The product is registered before the final add.
    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_older <= i_older;
    end

    // Taking the upper product bits is an arithmetic shift, so it floors.
    assign o_result = r_older
        + r_prod[srs_pkg::FRAC_BITS+srs_pkg::SAMPLE_W-1:srs_pkg::FRAC_BITS];

endmodule
